// ----- rtl/kxd_pkg.sv -----
// Shared types, constants and key table for the XOR key-table decrypt parser.
// No dependencies; used by every file in rtl/.
package kxd_pkg;

    localparam int KEY_LEN = 118;
    localparam int KEY_POS_W = 7;

    localparam logic [31:0] SIG_FIRST  = 32'h4651_5641;
    localparam logic [31:0] SIG_SECOND = 32'h4149_534E;

    // Built-in keys, first character at position 0, padded with zero bytes to 128.
    localparam logic [8*128-1:0] KEY_FIRST = {
        "AVQF3FCKE50GRIAYXJP2AMEYO5QGA0JGIIH2NHBTVOA1VOGGU5H3GSSIARKPRQPQKKYEOI",
        "AQG1XRX0J4F5OEAEFI4DD3LL45VJTVOA1VOGGUKE50GRIAYX",
        80'h0
    };
    localparam logic [8*128-1:0] KEY_SECOND = {
        "NSIARKPRQPHBTE50GRIH3AYXJP2AMF3FCEYAVQO5QGA0JGIIH2AYXKVOA1VOGGU5GSQKKY",
        "EOIAQG1XRX0J4F5OEAEFI4DD3LL45VJTVOA1VOGGUKE50GRI",
        80'h0
    };

    typedef enum logic [2:0] {
        PH_DIR    = 3'd0,
        PH_COUNT  = 3'd1,
        PH_FNAME  = 3'd2,
        PH_OFFSET = 3'd3,
        PH_FLAGS  = 3'd4,
        PH_EXTRA  = 3'd5,
        PH_SIZE   = 3'd6
    } kxd_phase_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_KEY = 2'd1,
        ST_TRUNC   = 2'd2
    } kxd_status_t;

    typedef struct packed {
        logic [7:0]  plain;
        logic [2:0]  tag;
        logic [1:0]  idx;
        logic        field_end;
        kxd_status_t status;
        logic        last;
    } kxd_result_t;

    function automatic logic [7:0] key_byte(input logic choice,
                                            input logic [KEY_POS_W-1:0] pos);
        logic [8*128-1:0] sel;
        sel = choice ? KEY_SECOND : KEY_FIRST;
        // byte at position p sits at bit offset 8*(127-p)
        return sel[{~pos, 3'b000} +: 8];
    endfunction

endpackage

// ----- rtl/kxd_keystream.sv -----
// Key selection and wrapping key position for the decrypt parser.
// Depends on kxd_pkg.
module kxd_keystream (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       load,
    input  logic       choice,
    input  logic       clear,
    output logic [7:0] key
);

    logic                         choice_reg;
    logic                         choice_next;
    logic [kxd_pkg::KEY_POS_W-1:0] pos_reg;
    logic [kxd_pkg::KEY_POS_W-1:0] pos_next;
    logic [kxd_pkg::KEY_POS_W:0]   pos_inc;

    assign key     = kxd_pkg::key_byte(choice_reg, pos_reg);
    assign pos_inc = {1'b0, pos_reg} + 1'b1;

    always_comb
    begin
        choice_next = choice_reg;
        pos_next    = pos_reg;
        if (load)
        begin
            choice_next = choice;
        end
        if (advance)
        begin
            if (pos_inc >= (kxd_pkg::KEY_POS_W + 1)'(kxd_pkg::KEY_LEN))
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_inc[kxd_pkg::KEY_POS_W-1:0];
            end
        end
        if (clear)
        begin
            choice_next = 1'b0;
            pos_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            choice_reg <= 1'b0;
            pos_reg    <= '0;
        end
        else
        begin
            choice_reg <= choice_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

// ----- rtl/kxd_parser.sv -----
// Record parser: tags each plaintext byte and tracks phase, dword byte and file count.
// Depends on kxd_pkg.
module kxd_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 clear,
    input  logic [7:0]           plain,
    output kxd_pkg::kxd_result_t result,
    output logic                 boundary
);

    kxd_pkg::kxd_phase_t phase_reg;
    kxd_pkg::kxd_phase_t phase_next;
    kxd_pkg::kxd_phase_t eff;
    logic [1:0]          idx_reg;
    logic [1:0]          idx_next;
    logic [31:0]         files_reg;
    logic [31:0]         files_next;
    logic [31:0]         files_upd;
    logic                is_string;
    logic                end_flag;

    always_comb
    begin
        case (phase_reg)
            kxd_pkg::PH_COUNT, kxd_pkg::PH_FNAME, kxd_pkg::PH_OFFSET,
            kxd_pkg::PH_FLAGS, kxd_pkg::PH_EXTRA, kxd_pkg::PH_SIZE:
                eff = phase_reg;
            default:
                eff = kxd_pkg::PH_DIR;
        endcase
    end

    assign is_string = (eff == kxd_pkg::PH_DIR) || (eff == kxd_pkg::PH_FNAME);

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        files_upd  = files_reg;
        boundary   = 1'b0;
        if (is_string)
        begin
            end_flag = (plain == 8'd0);
            if (end_flag)
            begin
                phase_next = kxd_pkg::kxd_phase_t'(eff + 3'd1);
                idx_next   = 2'd0;
            end
            else
            begin
                phase_next = eff;
            end
        end
        else
        begin
            end_flag = (idx_reg == 2'd3);
            idx_next = idx_reg + 2'd1;
            if (eff == kxd_pkg::PH_COUNT)
            begin
                if (idx_reg == 2'd0)
                begin
                    files_upd = {24'd0, plain};
                end
                else
                begin
                    files_upd = files_reg | ({24'd0, plain} << {idx_reg, 3'b000});
                end
            end
            if (!end_flag)
            begin
                phase_next = eff;
            end
            else if (eff == kxd_pkg::PH_COUNT || eff == kxd_pkg::PH_SIZE)
            begin
                if (eff == kxd_pkg::PH_SIZE)
                begin
                    files_upd = files_reg - 32'd1;
                end
                phase_next = (files_upd == 32'd0) ? kxd_pkg::PH_DIR : kxd_pkg::PH_FNAME;
                boundary   = (files_upd == 32'd0);
            end
            else
            begin
                phase_next = kxd_pkg::kxd_phase_t'(eff + 3'd1);
            end
        end
    end

    always_comb
    begin
        result.plain     = plain;
        result.tag       = eff;
        result.idx       = is_string ? 2'd0 : idx_reg;
        result.field_end = end_flag;
        result.status    = kxd_pkg::ST_OK;
        result.last      = 1'b0;
    end

    assign files_next = files_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= kxd_pkg::PH_DIR;
            idx_reg   <= 2'd0;
            files_reg <= 32'd0;
        end
        else if (clear)
        begin
            phase_reg <= kxd_pkg::PH_DIR;
            idx_reg   <= 2'd0;
            files_reg <= 32'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            files_reg <= files_next;
        end
    end

endmodule

// ----- rtl/kxd_result_buf.sv -----
// Two-entry result buffer: output register plus skid slot.
// Depends on kxd_pkg.
module kxd_result_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  kxd_pkg::kxd_result_t push_data,
    output logic                 full,
    output logic                 out_valid,
    input  logic                 out_ready,
    output kxd_pkg::kxd_result_t out_data
);

    kxd_pkg::kxd_result_t head_reg;
    kxd_pkg::kxd_result_t skid_reg;
    logic [1:0]           count_reg;
    logic [1:0]           count_next;
    logic                 pop;

    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign out_data  = head_reg;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // payload slots; push never arrives while full
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (count_reg == 2'd2)
            begin
                head_reg <= skid_reg;
                if (push)
                begin
                    skid_reg <= push_data;
                end
            end
            else if (push)
            begin
                head_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                head_reg <= push_data;
            end
            else
            begin
                skid_reg <= push_data;
            end
        end
    end

endmodule

// ----- rtl/xor_key_table_decrypt_parser_unit.sv -----
// Top level of the XOR key-table decrypt parser.
// Depends on kxd_pkg, kxd_keystream, kxd_parser and kxd_result_buf.
//
// Takes one encrypted table byte per cycle while item_ready is high and returns the
// decrypted byte tagged with its record field. The first three bytes give no result
// unless last_byte ends the table there; the fourth checks the key signature and,
// when it is good, releases the four decrypted header bytes one after another,
// during which no new byte is taken. Every later byte gives one result. A bad
// signature gives one status result per byte until last_byte ends the table, and
// any transaction carrying last_byte returns the block to its reset state. A
// two-entry result buffer keeps input taking while one result waits downstream.
module xor_key_table_decrypt_parser_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [7:0] raw_byte,
    input  logic       last_byte,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] plain_byte,
    output logic [2:0] field_tag,
    output logic [1:0] byte_in_field,
    output logic       field_end,
    output logic [1:0] status,
    output logic       last_result
);

    logic [7:0]  hdr_bytes_reg [0:3];
    logic [1:0]  hdr_count_reg;
    logic [1:0]  hdr_count_next;
    logic        hdr_done_reg;
    logic        hdr_done_next;
    logic        err_reg;
    logic        err_next;
    logic        burst_reg;
    logic        burst_next;
    logic [1:0]  burst_idx_reg;
    logic [1:0]  burst_idx_next;
    logic        burst_last_reg;

    logic        accept;
    logic        burst_step;
    logic        buf_full;
    logic [31:0] sig;
    logic        sig_first;
    logic        sig_second;
    logic        push;
    logic        parse_step;
    logic        clear_all;
    logic        key_load;
    logic [7:0]  key;
    logic [7:0]  cipher;
    logic        boundary;

    kxd_pkg::kxd_result_t parse_res;
    kxd_pkg::kxd_result_t push_data;
    kxd_pkg::kxd_result_t head;

    assign item_ready = !burst_reg && !buf_full;
    assign accept     = item_valid && item_ready;
    assign burst_step = burst_reg && !buf_full;

    assign sig        = {raw_byte, hdr_bytes_reg[2], hdr_bytes_reg[1], hdr_bytes_reg[0]};
    assign sig_first  = (sig == kxd_pkg::SIG_FIRST);
    assign sig_second = (sig == kxd_pkg::SIG_SECOND);
    assign cipher     = burst_reg ? hdr_bytes_reg[burst_idx_reg] : raw_byte;

    always_comb
    begin
        push           = 1'b0;
        push_data      = parse_res;
        parse_step     = 1'b0;
        clear_all      = 1'b0;
        key_load       = 1'b0;
        hdr_count_next = hdr_count_reg;
        hdr_done_next  = hdr_done_reg;
        err_next       = err_reg;
        burst_next     = burst_reg;
        burst_idx_next = burst_idx_reg;

        if (burst_step)
        begin
            push           = 1'b1;
            parse_step     = 1'b1;
            burst_idx_next = burst_idx_reg + 2'd1;
            if (burst_idx_reg == 2'd3)
            begin
                burst_next     = 1'b0;
                push_data.last = 1'b1;
                if (burst_last_reg)
                begin
                    clear_all = 1'b1;
                    if (!boundary)
                    begin
                        push_data.status = kxd_pkg::ST_TRUNC;
                    end
                end
            end
        end
        else if (accept)
        begin
            clear_all = last_byte;
            if (err_reg || (!hdr_done_reg && hdr_count_reg == 2'd3 && !sig_first && !sig_second))
            begin
                push      = 1'b1;
                push_data = '{plain: 8'd0, tag: 3'd0, idx: 2'd0, field_end: 1'b0,
                              status: kxd_pkg::ST_BAD_KEY, last: 1'b1};
                err_next  = 1'b1;
            end
            else if (!hdr_done_reg && hdr_count_reg != 2'd3)
            begin
                hdr_count_next = hdr_count_reg + 2'd1;
                push           = last_byte;
                push_data      = '{plain: 8'd0, tag: 3'd0, idx: 2'd0, field_end: 1'b0,
                                   status: kxd_pkg::ST_TRUNC, last: 1'b1};
            end
            else if (!hdr_done_reg)
            begin
                // good signature: replay the four header bytes through the parser
                clear_all      = 1'b0;
                key_load       = 1'b1;
                hdr_done_next  = 1'b1;
                burst_next     = 1'b1;
                burst_idx_next = 2'd0;
            end
            else
            begin
                push           = 1'b1;
                parse_step     = 1'b1;
                push_data.last = 1'b1;
                if (last_byte && !boundary)
                begin
                    push_data.status = kxd_pkg::ST_TRUNC;
                end
            end
        end

        if (clear_all)
        begin
            hdr_count_next = 2'd0;
            hdr_done_next  = 1'b0;
            err_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_count_reg <= 2'd0;
            hdr_done_reg  <= 1'b0;
            err_reg       <= 1'b0;
            burst_reg     <= 1'b0;
            burst_idx_reg <= 2'd0;
        end
        else
        begin
            hdr_count_reg <= hdr_count_next;
            hdr_done_reg  <= hdr_done_next;
            err_reg       <= err_next;
            burst_reg     <= burst_next;
            burst_idx_reg <= burst_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !hdr_done_reg && !err_reg)
        begin
            hdr_bytes_reg[hdr_count_reg] <= raw_byte;
            burst_last_reg               <= last_byte;
        end
    end

    kxd_keystream u_keystream (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (parse_step),
        .load    (key_load),
        .choice  (sig_second),
        .clear   (clear_all),
        .key     (key)
    );

    kxd_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (parse_step),
        .clear    (clear_all),
        .plain    (cipher ^ key),
        .result   (parse_res),
        .boundary (boundary)
    );

    kxd_result_buf u_result_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (buf_full),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_data  (head)
    );

    assign plain_byte    = head.plain;
    assign field_tag     = head.tag;
    assign byte_in_field = head.idx;
    assign field_end     = head.field_end;
    assign status        = head.status;
    assign last_result   = head.last;

endmodule

// ----- rtl/kxd_checker.sv -----
// Port-level checks on the result channel of the decrypt parser, bound to the top level.
// Depends on kxd_pkg and xor_key_table_decrypt_parser_unit.
module kxd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       result_valid,
    input logic       result_ready,
    input logic [7:0] plain_byte,
    input logic [2:0] field_tag,
    input logic [1:0] byte_in_field,
    input logic       field_end,
    input logic [1:0] status,
    input logic       last_result
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(plain_byte) && $stable(status)
                                          && $stable(field_tag))
        else $error("stalled result changed");

    a_bad_key: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == kxd_pkg::ST_BAD_KEY |->
            last_result && plain_byte == 8'd0 && field_tag == 3'd0 && !field_end)
        else $error("malformed signature error transaction");

    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == kxd_pkg::ST_TRUNC |-> last_result)
        else $error("truncation flagged before final result");

    a_string_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (field_tag == 3'(kxd_pkg::PH_DIR) || field_tag == 3'(kxd_pkg::PH_FNAME))
            |-> byte_in_field == 2'd0 && (!field_end || plain_byte == 8'd0))
        else $error("string field tagged wrongly");

endmodule

bind xor_key_table_decrypt_parser_unit kxd_checker u_kxd_checker (.*);

// ----- dv/xor_key_table_decrypt_parser_unit_tb.sv -----
// Self-checking bench for xor_key_table_decrypt_parser_unit: short directed tables, then
// random encrypted allocation tables, every result compared with a local decrypt/tag model.
// Depends on kxd_pkg (phase and status enums) and the RTL in rtl/.
module xor_key_table_decrypt_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_KEY_LEN = 118;
    localparam int RANDOM_BYTES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int MAX_REPORTS = 50;

    localparam logic [31:0] MAGIC_A = 32'h4651_5641;
    localparam logic [31:0] MAGIC_B = 32'h4149_534E;
    localparam logic [8*118-1:0] XOR_KEY_A = {
        "AVQF3FCKE50GRIAYXJP2AMEYO5QGA0JGIIH2NHBTVOA1VOGGU5H3GSSIARKPRQPQKKYEOI",
        "AQG1XRX0J4F5OEAEFI4DD3LL45VJTVOA1VOGGUKE50GRIAYX"
    };
    localparam logic [8*118-1:0] XOR_KEY_B = {
        "NSIARKPRQPHBTE50GRIH3AYXJP2AMF3FCEYAVQO5QGA0JGIIH2AYXKVOA1VOGGU5GSQKKY",
        "EOIAQG1XRX0J4F5OEAEFI4DD3LL45VJTVOA1VOGGUKE50GRI"
    };

    typedef struct {
        logic [7:0]           plain;
        kxd_pkg::kxd_phase_t  tag;
        logic [1:0]           idx;
        logic                 fend;
        kxd_pkg::kxd_status_t st;
        logic                 lastr;
    } tag_rec_t;

    typedef enum logic [1:0] {ROW_MODEL, ROW_SILENT, ROW_ONE} row_mode_t;

    typedef struct {
        logic [7:0]           raw;
        logic                 last;
        row_mode_t            mode;
        kxd_pkg::kxd_status_t st;
    } stim_row_t;

    typedef struct {
        logic [7:0] raw;
        logic       last;
    } table_byte_t;

    localparam int DIRECTED_ROWS = 25;

    // SILENT and ONE rows carry the expectation typed in; MODEL rows go to the predictor
    stim_row_t directed [DIRECTED_ROWS] = '{
        // table ends inside the signature
        '{8'h41, 1'b0, ROW_SILENT, kxd_pkg::ST_OK},
        '{8'h56, 1'b1, ROW_ONE,    kxd_pkg::ST_TRUNC},
        // unknown signature, latched until last_byte
        '{8'h00, 1'b0, ROW_SILENT, kxd_pkg::ST_OK},
        '{8'h00, 1'b0, ROW_SILENT, kxd_pkg::ST_OK},
        '{8'h00, 1'b0, ROW_SILENT, kxd_pkg::ST_OK},
        '{8'hFF, 1'b0, ROW_ONE,    kxd_pkg::ST_BAD_KEY},
        '{8'hFF, 1'b0, ROW_ONE,    kxd_pkg::ST_BAD_KEY},
        '{8'h00, 1'b1, ROW_ONE,    kxd_pkg::ST_BAD_KEY},
        // first key, cut off inside a directory name
        '{8'h41, 1'b0, ROW_SILENT, kxd_pkg::ST_OK},
        '{8'h56, 1'b0, ROW_SILENT, kxd_pkg::ST_OK},
        '{8'h51, 1'b0, ROW_SILENT, kxd_pkg::ST_OK},
        '{8'h46, 1'b0, ROW_MODEL,  kxd_pkg::ST_OK},
        '{8'h33, 1'b0, ROW_MODEL,  kxd_pkg::ST_OK},
        '{8'hFF, 1'b0, ROW_MODEL,  kxd_pkg::ST_OK},
        '{8'h00, 1'b0, ROW_MODEL,  kxd_pkg::ST_OK},
        '{8'h5A, 1'b1, ROW_MODEL,  kxd_pkg::ST_OK},
        // second key, last_byte on the signature burst
        '{8'h4E, 1'b0, ROW_SILENT, kxd_pkg::ST_OK},
        '{8'h53, 1'b0, ROW_SILENT, kxd_pkg::ST_OK},
        '{8'h49, 1'b0, ROW_SILENT, kxd_pkg::ST_OK},
        '{8'h41, 1'b1, ROW_MODEL,  kxd_pkg::ST_OK},
        // second key, clean end on the file count
        '{8'h4E, 1'b0, ROW_SILENT, kxd_pkg::ST_OK},
        '{8'h53, 1'b0, ROW_SILENT, kxd_pkg::ST_OK},
        '{8'h49, 1'b0, ROW_SILENT, kxd_pkg::ST_OK},
        '{8'h41, 1'b0, ROW_MODEL,  kxd_pkg::ST_OK},
        '{8'h52, 1'b1, ROW_MODEL,  kxd_pkg::ST_OK}
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       item_valid;
    logic       item_ready;
    logic [7:0] raw_byte;
    logic       last_byte;
    logic       result_valid;
    logic       result_ready;
    logic [7:0] plain_byte;
    logic [2:0] field_tag;
    logic [1:0] byte_in_field;
    logic       field_end;
    logic [1:0] status;
    logic       last_result;

    // predictor state
    logic [7:0]          sig_buf [3];
    int                  sig_seen;
    bit                  key_locked;
    bit                  key_sel;
    int                  key_pos;
    kxd_pkg::kxd_phase_t phase;
    logic [1:0]          dw_idx;
    logic [31:0]         files_left;
    bit                  sig_bad;

    tag_rec_t    expected_plain [$];
    table_byte_t feed_q [$];

    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int sent = 0;
    int checked = 0;
    int mismatches = 0;
    int tables = 0;
    int intact = 0;
    int quiet = 0;

    xor_key_table_decrypt_parser_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .raw_byte     (raw_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .plain_byte   (plain_byte),
        .field_tag    (field_tag),
        .byte_in_field(byte_in_field),
        .field_end    (field_end),
        .status       (status),
        .last_result  (last_result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [7:0] key_at(input bit sel, input int pos);
        return sel ? XOR_KEY_B[8*(TABLE_KEY_LEN-1-pos) +: 8]
                   : XOR_KEY_A[8*(TABLE_KEY_LEN-1-pos) +: 8];
    endfunction

    function automatic void clear_table_state();
        sig_buf    = '{8'h00, 8'h00, 8'h00};
        sig_seen   = 0;
        key_locked = 1'b0;
        key_sel    = 1'b0;
        key_pos    = 0;
        phase      = kxd_pkg::PH_DIR;
        dw_idx     = 2'd0;
        files_left = 32'd0;
        sig_bad    = 1'b0;
    endfunction

    function automatic logic [7:0] unmask(input logic [7:0] raw);
        logic [7:0] k;
        k = key_at(key_sel, key_pos);
        key_pos = (key_pos + 1 >= TABLE_KEY_LEN) ? 0 : key_pos + 1;
        return raw ^ k;
    endfunction

    // tags one plaintext byte; true when it closes a whole directory record
    function automatic bit tag_plain(input logic [7:0] p, output tag_rec_t r);
        bit closed;
        closed = 1'b0;
        if (phase == kxd_pkg::PH_DIR || phase == kxd_pkg::PH_FNAME)
        begin
            r = '{p, phase, 2'd0, p == 8'h00, kxd_pkg::ST_OK, 1'b0};
            if (p == 8'h00)
            begin
                phase  = kxd_pkg::kxd_phase_t'(phase + 3'd1);
                dw_idx = 2'd0;
            end
        end
        else
        begin
            if (phase == kxd_pkg::PH_COUNT)
                files_left = (dw_idx == 2'd0) ? {24'd0, p}
                                              : files_left | ({24'd0, p} << (8 * dw_idx));
            r = '{p, phase, dw_idx, dw_idx == 2'd3, kxd_pkg::ST_OK, 1'b0};
            if (dw_idx == 2'd3)
            begin
                case (phase)
                    kxd_pkg::PH_COUNT:
                        phase = (files_left == 32'd0) ? kxd_pkg::PH_DIR : kxd_pkg::PH_FNAME;
                    kxd_pkg::PH_SIZE:
                    begin
                        files_left = files_left - 32'd1;
                        phase = (files_left == 32'd0) ? kxd_pkg::PH_DIR : kxd_pkg::PH_FNAME;
                    end
                    default:
                        phase = kxd_pkg::kxd_phase_t'(phase + 3'd1);
                endcase
                closed = (phase == kxd_pkg::PH_DIR);
            end
            dw_idx = dw_idx + 2'd1;
        end
        return closed;
    endfunction

    task automatic predict_decrypt(input logic [7:0] raw, input logic last);
        tag_rec_t    burst [$];
        tag_rec_t    r;
        bit          closed;
        logic [31:0] sig;
        closed = 1'b0;
        if (sig_bad)
        begin
            burst.insert(burst.size(), tag_rec_t'{8'h00, kxd_pkg::PH_DIR, 2'd0, 1'b0,
                                                  kxd_pkg::ST_BAD_KEY, 1'b1});
            closed = 1'b1;
        end
        else if (!key_locked && sig_seen < 3)
        begin
            sig_buf[sig_seen] = raw;
            sig_seen++;
            if (last)
                burst.insert(burst.size(), tag_rec_t'{8'h00, kxd_pkg::PH_DIR, 2'd0, 1'b0,
                                                      kxd_pkg::ST_TRUNC, 1'b1});
            closed = 1'b1;
        end
        else if (!key_locked)
        begin
            sig = {raw, sig_buf[2], sig_buf[1], sig_buf[0]};
            if (sig == MAGIC_A || sig == MAGIC_B)
            begin
                key_sel    = (sig == MAGIC_B);
                key_locked = 1'b1;
                for (int i = 0; i < 4; i++)
                begin
                    closed = tag_plain(unmask(i < 3 ? sig_buf[i] : raw), r);
                    burst.insert(burst.size(), r);
                end
            end
            else
            begin
                sig_bad = 1'b1;
                burst.insert(burst.size(), tag_rec_t'{8'h00, kxd_pkg::PH_DIR, 2'd0, 1'b0,
                                                      kxd_pkg::ST_BAD_KEY, 1'b1});
                closed = 1'b1;
            end
        end
        else
        begin
            closed = tag_plain(unmask(raw), r);
            burst.insert(burst.size(), r);
        end
        if (burst.size() > 0)
        begin
            burst[$].lastr = 1'b1;
            if (last && !closed && burst[$].st == kxd_pkg::ST_OK)
                burst[$].st = kxd_pkg::ST_TRUNC;
        end
        foreach (burst[i])
            expected_plain.insert(expected_plain.size(), burst[i]);
        if (last)
            clear_table_state();
    endtask

    // one input transaction, with random idle cycles ahead of it
    task automatic offer(input logic [7:0] b, input logic l, input row_mode_t mode,
                         input kxd_pkg::kxd_status_t st);
        int mark;
        @(negedge clk);
        while (!calm && $urandom_range(99) < 8)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        raw_byte   <= b;
        last_byte  <= l;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sent++;
        mark = expected_plain.size();
        predict_decrypt(b, l);
        if (mode != ROW_MODEL)
        begin
            while (expected_plain.size() > mark)
                void'(expected_plain.pop_back());
            if (mode == ROW_ONE)
                expected_plain.insert(expected_plain.size(),
                                      tag_rec_t'{8'h00, kxd_pkg::PH_DIR, 2'd0, 1'b0, st, 1'b1});
        end
    endtask

    // fills feed_q with one table: mostly well-formed records, some damaged or junk
    task automatic build_table(input bit big);
        logic [7:0] plain [$];
        int         pick;
        int         nf;
        int         cut;
        bit         sel;
        bit         scramble;
        feed_q.delete();
        pick = big ? 0 : $urandom_range(99);
        sel = $urandom_range(1);
        scramble = 1'b1;
        if (pick < 65)
        begin
            // signature decrypts to zeros: empty name and the low count bytes
            plain = '{8'h00, 8'h00, 8'h00, 8'h00};
            plain.insert(plain.size(),
                         ($urandom_range(19) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
            repeat (big ? 4 : $urandom_range(1, 3))
            begin
                repeat ($urandom_range(3))
                    plain.insert(plain.size(), 8'($urandom_range(1, 255)));
                plain.insert(plain.size(), 8'h00);
                nf = big ? 3 : $urandom_range(2);
                plain.insert(plain.size(), 8'(nf));
                repeat (3)
                    plain.insert(plain.size(), 8'h00);
                repeat (nf)
                begin
                    repeat ($urandom_range(3))
                        plain.insert(plain.size(), 8'($urandom_range(1, 255)));
                    plain.insert(plain.size(), 8'h00);
                    repeat (16)
                        plain.insert(plain.size(), 8'($urandom));
                end
            end
            intact++;
        end
        else if (pick < 80)
        begin
            // almost surely an unknown signature
            scramble = 1'b0;
            repeat ($urandom_range(4, 9))
                feed_q.insert(feed_q.size(), table_byte_t'{8'($urandom), 1'b0});
        end
        else if (pick < 90)
        begin
            // good signature followed by junk
            plain = '{8'h00, 8'h00, 8'h00, 8'h00};
            repeat ($urandom_range(1, 20))
                plain.insert(plain.size(), 8'($urandom));
        end
        else
        begin
            scramble = 1'b0;
            repeat ($urandom_range(1, 3))
                feed_q.insert(feed_q.size(), table_byte_t'{8'($urandom), 1'b0});
        end
        if (scramble)
        begin
            foreach (plain[i])
                feed_q.insert(feed_q.size(),
                              table_byte_t'{plain[i] ^ key_at(sel, i % TABLE_KEY_LEN), 1'b0});
            if (pick < 65 && !big && $urandom_range(3) == 0)
            begin
                cut = $urandom_range(1, feed_q.size() - 1);
                while (feed_q.size() > cut)
                    void'(feed_q.pop_back());
            end
        end
        feed_q[$].last = 1'b1;
    endtask

    initial
    begin : stimulus
        bit first;
        item_valid = 1'b0;
        raw_byte   = 8'h00;
        last_byte  = 1'b0;
        rst_n      = 1'b0;
        clear_table_state();
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            offer(directed[i].raw, directed[i].last, directed[i].mode, directed[i].st);
        @(negedge clk);
        item_valid <= 1'b0;
        // sender waits here until the block has emptied
        while (expected_plain.size() != 0)
            @(posedge clk);

        first = 1'b1;
        while (sent < DIRECTED_ROWS + RANDOM_BYTES)
        begin
            build_table(first);
            first = 1'b0;
            tables++;
            foreach (feed_q[j])
            begin
                if (sent == DIRECTED_ROWS + 110)
                    hold_req = 1'b1;
                calm = (sent >= DIRECTED_ROWS + 180 && sent < DIRECTED_ROWS + 250);
                offer(feed_q[j].raw, feed_q[j].last, ROW_MODEL, kxd_pkg::ST_OK);
            end
        end
        @(negedge clk);
        item_valid <= 1'b0;
        calm = 1'b0;

        while (expected_plain.size() != 0)
            @(posedge clk);
        repeat (16)
            @(posedge clk);
        $display("Sent %0d table bytes over %0d random tables (%0d built from whole records)",
                 sent, tables, intact);
        $display("Checked %0d results: both keys, bad signatures, truncation, key wrap",
                 checked);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= calm || ($urandom_range(99) >= 8);
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        tag_rec_t w;
        if (rst_n && result_valid && result_ready)
        begin
            checked++;
            if (expected_plain.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $error("result transaction with nothing expected, plain_byte %0h",
                           plain_byte);
            end
            else
            begin
                w = expected_plain.pop_front();
                check_field("plain_byte", w.plain, plain_byte);
                check_field("field_tag", w.tag, field_tag);
                check_field("byte_in_field", w.idx, byte_in_field);
                check_field("field_end", w.fend, field_end);
                check_field("status", w.st, status);
                check_field("last_result", w.lastr, last_result);
            end
        end
    end

    // ends the run if neither side has moved a transaction for too long
    always @(posedge clk)
    begin : watchdog
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet == STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
